// File: hw/rtl/char_lcd_nibble_interface_macros.svh
// ---------------------------------------------------------------------------
// char_lcd_nibble_interface_macros
// assertion macros shared by the lcd nibble front end
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CLNI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CLNI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLNI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CLNI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hw/rtl/clni_pkg.sv
// ---------------------------------------------------------------------------
// clni_pkg
// types, constants, tables and microprogram of the lcd nibble front end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package clni_pkg;

  localparam int unsigned MAX_SHIFT = 32;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COL_W     = 6;
  localparam int unsigned CNT_IN_W  = 6;
  localparam int unsigned CUR_W     = 3;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned SETTLE_W  = 11;
  localparam int unsigned PC_W      = 3;
  localparam int unsigned IDX_W     = 4;

  localparam logic [WAIT_W-1:0]   POWER_WAIT  = 16'd40000;
  localparam logic [WAIT_W-1:0]   NO_WAIT     = '0;
  localparam logic [SETTLE_W-1:0] SETTLE_NONE = '0;
  localparam logic [SETTLE_W-1:0] SETTLE_LOW  = 11'd30;
  localparam logic [SETTLE_W-1:0] SETTLE_LONG = 11'd2030;

  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  localparam logic [CHAR_W-1:0] CMD_CLEAR     = 8'b0000_0001;
  localparam logic [CHAR_W-1:0] CMD_HOME      = 8'b0000_0010;
  localparam logic [CHAR_W-1:0] CMD_DISPLAY   = 8'b0000_1000;
  localparam logic [CHAR_W-1:0] CMD_SHIFT_L   = 8'b0001_1000;
  localparam logic [CHAR_W-1:0] CMD_SHIFT_R   = 8'b0001_1100;
  localparam logic [CHAR_W-1:0] CMD_GOTO_ROW1 = 8'b1100_0000;

  localparam logic [IDX_W-1:0] INIT_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] INIT_CLEAR = 4'd9;
  localparam logic [IDX_W-1:0] INIT_LAST  = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_PUT_CHAR = 3'd0,
    OP_GOTO     = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_HOME     = 3'd3,
    OP_SHIFT_L  = 3'd4,
    OP_SHIFT_R  = 3'd5,
    OP_CURSOR   = 3'd6,
    OP_INIT     = 3'd7
  } op_e;

  // microprogram addresses
  typedef enum logic [PC_W-1:0] {
    PC_SINGLE_HI = 3'd0,
    PC_SINGLE_LO = 3'd1,
    PC_SHIFT_HI  = 3'd2,
    PC_SHIFT_LO  = 3'd3,
    PC_INIT_HI   = 3'd4,
    PC_INIT_LO   = 3'd5
  } pc_e;

  typedef enum logic {
    SRC_REQ  = 1'b0,
    SRC_INIT = 1'b1
  } src_e;

  typedef enum logic [1:0] {
    STL_NONE = 2'd0,
    STL_REQ  = 2'd1,
    STL_INIT = 2'd2
  } settle_sel_e;

  typedef enum logic [1:0] {
    SEQ_NEXT      = 2'd0,
    SEQ_END       = 2'd1,
    SEQ_LOOP_CNT  = 2'd2,
    SEQ_LOOP_INIT = 2'd3
  } seq_e;

  typedef struct packed {
    src_e        src;
    logic        high_half;
    settle_sel_e settle_sel;
    logic        power_wait;
    seq_e        seq;
    pc_e         target;
  } ctl_t;

  function automatic ctl_t micro_word(pc_e pc);
    ctl_t w;
    w = '{src: SRC_REQ, high_half: 1'b1, settle_sel: STL_NONE, power_wait: 1'b0,
          seq: SEQ_END, target: PC_SINGLE_HI};
    unique case (pc)
      PC_SINGLE_HI: w = '{SRC_REQ, 1'b1, STL_NONE, 1'b0, SEQ_NEXT, PC_SINGLE_LO};
      PC_SINGLE_LO: w = '{SRC_REQ, 1'b0, STL_REQ, 1'b0, SEQ_END, PC_SINGLE_HI};
      PC_SHIFT_HI:  w = '{SRC_REQ, 1'b1, STL_NONE, 1'b0, SEQ_NEXT, PC_SHIFT_LO};
      PC_SHIFT_LO:  w = '{SRC_REQ, 1'b0, STL_REQ, 1'b0, SEQ_LOOP_CNT, PC_SHIFT_HI};
      PC_INIT_HI:   w = '{SRC_INIT, 1'b1, STL_NONE, 1'b1, SEQ_NEXT, PC_INIT_LO};
      PC_INIT_LO:   w = '{SRC_INIT, 1'b0, STL_INIT, 1'b0, SEQ_LOOP_INIT, PC_INIT_HI};
      default:      w = '{SRC_REQ, 1'b1, STL_NONE, 1'b0, SEQ_END, PC_SINGLE_HI};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] init_byte(logic [IDX_W-1:0] idx);
    logic [CHAR_W-1:0] b;
    unique case (idx)
      4'd0:    b = 8'h03;
      4'd1:    b = 8'h33;
      4'd2:    b = 8'h22;
      4'd3:    b = 8'b0010_1001;
      4'd4:    b = 8'h14;
      4'd5:    b = 8'b0111_1000;
      4'd6:    b = 8'h55;
      4'd7:    b = 8'h6D;
      4'd8:    b = 8'h0C;
      4'd9:    b = 8'h01;
      4'd10:   b = 8'h06;
      4'd11:   b = 8'h28;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // latin-1 umlauts to the display's character rom
  function automatic logic [CHAR_W-1:0] remap_char(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    unique case (c)
      8'hE4:   r = 8'h84;
      8'hC4:   r = 8'h8E;
      8'hF6:   r = 8'h94;
      8'hD6:   r = 8'h99;
      8'hFC:   r = 8'h81;
      8'hDC:   r = 8'h9A;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/clni_req_if.sv
// ---------------------------------------------------------------------------
// clni_req_if
// request channel of the lcd nibble front end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface clni_req_if;
  logic                         valid;
  logic                         ready;
  logic [clni_pkg::OP_W-1:0]     operation;
  logic [clni_pkg::CHAR_W-1:0]   char_code;
  logic [clni_pkg::COL_W-1:0]    column;
  logic                         row;
  logic [clni_pkg::CNT_IN_W-1:0] shift_count;
  logic [clni_pkg::CUR_W-1:0]    cursor_bits;

  modport source (
    output valid, operation, char_code, column, row, shift_count, cursor_bits,
    input  ready
  );
  modport sink (
    input  valid, operation, char_code, column, row, shift_count, cursor_bits,
    output ready
  );
endinterface

// File: hw/rtl/clni_nib_if.sv
// ---------------------------------------------------------------------------
// clni_nib_if
// nibble channel of the lcd nibble front end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface clni_nib_if;
  logic                         valid;
  logic                         ready;
  logic [clni_pkg::NIB_W-1:0]    nibble;
  logic                         register_select;
  logic [clni_pkg::WAIT_W-1:0]   wait_before_us;
  logic [clni_pkg::SETTLE_W-1:0] settle_us;
  logic                         last;

  modport source (
    output valid, nibble, register_select, wait_before_us, settle_us, last,
    input  ready
  );
  modport sink (
    input  valid, nibble, register_select, wait_before_us, settle_us, last,
    output ready
  );
endinterface

// File: hw/rtl/char_lcd_nibble_interface.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_interface
// character lcd request front end, 4-bit mode, microcoded nibble sequencer
// ---------------------------------------------------------------------------
// usage:
//   req_i takes one request item (operation and its arguments); nib_o gives
//   a run of nibble items, high nibble first, each with register select,
//   a wait before it, a settle time after it and last on the final one.
//   a request is taken when the sequencer is idle; the run starts in the
//   next cycle and gives at most one nibble per cycle: 2 nibbles for
//   single commands, 2 per shift step (up to 2*MaxShift), 24 for init.
//   a request is taken again once its last nibble sits in the output
//   register, so req_i stays closed while the run is in progress.
//   a shift with a count of zero gives no nibble and frees the block at once.
//   the step counter walks a six-word microprogram; the shift loop and the
//   init loop are conditional jumps on a step count and a table index.
//   reset empties the output register and returns the sequencer to idle.
//   when nib_o is stalled the output register holds and the sequencer waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "char_lcd_nibble_interface_macros.svh"

module char_lcd_nibble_interface #(
  parameter int unsigned MaxShift = clni_pkg::MAX_SHIFT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  clni_req_if.sink          req_i,
  clni_nib_if.source        nib_o
);

  localparam int unsigned CntW = $clog2(MaxShift + 1);

  // request latch
  logic [clni_pkg::CHAR_W-1:0] byte_q, byte_d;
  logic                        rs_q, rs_d;
  logic                        long_q, long_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [clni_pkg::IDX_W-1:0]  idx_q, idx_d;

  // sequencer
  logic                        busy_q, busy_d;
  clni_pkg::pc_e               pc_q, pc_d;
  clni_pkg::ctl_t              ctl;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [clni_pkg::NIB_W-1:0]    out_nib_q, out_nib_d;
  logic                          out_rs_q, out_rs_d;
  logic [clni_pkg::WAIT_W-1:0]   out_wait_q, out_wait_d;
  logic [clni_pkg::SETTLE_W-1:0] out_settle_q, out_settle_d;
  logic                          out_last_q, out_last_d;

  logic                        accept;
  logic                        advance;
  logic [clni_pkg::CHAR_W-1:0] cur_byte;
  logic [CntW-1:0]             cnt_sat;
  clni_pkg::op_e               op;

  assign op      = clni_pkg::op_e'(req_i.operation);
  assign accept  = req_i.valid && req_i.ready;
  assign advance = busy_q && (!out_valid_q || nib_o.ready);
  assign ctl     = clni_pkg::micro_word(pc_q);

  assign req_i.ready = !busy_q;

  assign nib_o.valid           = out_valid_q;
  assign nib_o.nibble          = out_nib_q;
  assign nib_o.register_select = out_rs_q;
  assign nib_o.wait_before_us  = out_wait_q;
  assign nib_o.settle_us       = out_settle_q;
  assign nib_o.last            = out_last_q;

  assign cnt_sat = (req_i.shift_count > clni_pkg::CNT_IN_W'(MaxShift))
                   ? CntW'(MaxShift) : CntW'(req_i.shift_count);

  assign cur_byte = (ctl.src == clni_pkg::SRC_INIT) ? clni_pkg::init_byte(idx_q) : byte_q;

  always_comb begin
    byte_d       = byte_q;
    rs_d         = rs_q;
    long_d       = long_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    busy_d       = busy_q;
    pc_d         = pc_q;
    out_valid_d  = out_valid_q;
    out_nib_d    = out_nib_q;
    out_rs_d     = out_rs_q;
    out_wait_d   = out_wait_q;
    out_settle_d = out_settle_q;
    out_last_d   = out_last_q;

    if (out_valid_q && nib_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      rs_d   = 1'b0;
      long_d = 1'b0;
      cnt_d  = cnt_sat;
      idx_d  = clni_pkg::INIT_FIRST;
      busy_d = 1'b1;
      pc_d   = clni_pkg::PC_SINGLE_HI;
      byte_d = req_i.char_code;
      unique case (op)
        clni_pkg::OP_PUT_CHAR: begin
          if (req_i.char_code == clni_pkg::CH_LF || req_i.char_code == clni_pkg::CH_CR) begin
            byte_d = clni_pkg::CMD_GOTO_ROW1;
          end else if (req_i.char_code == clni_pkg::CH_FF) begin
            byte_d = clni_pkg::CMD_CLEAR;
            long_d = 1'b1;
          end else begin
            byte_d = clni_pkg::remap_char(req_i.char_code);
            rs_d   = 1'b1;
          end
        end
        clni_pkg::OP_GOTO: begin
          // row base 0x40 plus a 6-bit column never carries past bit 6
          byte_d = {1'b1, req_i.row, req_i.column};
        end
        clni_pkg::OP_CLEAR: begin
          byte_d = clni_pkg::CMD_CLEAR;
          long_d = 1'b1;
        end
        clni_pkg::OP_HOME: begin
          byte_d = clni_pkg::CMD_HOME;
          long_d = 1'b1;
        end
        clni_pkg::OP_SHIFT_L, clni_pkg::OP_SHIFT_R: begin
          byte_d = (op == clni_pkg::OP_SHIFT_L) ? clni_pkg::CMD_SHIFT_L : clni_pkg::CMD_SHIFT_R;
          pc_d   = clni_pkg::PC_SHIFT_HI;
          busy_d = (cnt_sat != '0);
        end
        clni_pkg::OP_CURSOR: begin
          byte_d = clni_pkg::CMD_DISPLAY | {5'b0, req_i.cursor_bits};
        end
        clni_pkg::OP_INIT: begin
          pc_d = clni_pkg::PC_INIT_HI;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end

    if (advance) begin
      out_valid_d = 1'b1;
      out_nib_d   = ctl.high_half ? cur_byte[7:4] : cur_byte[3:0];
      out_rs_d    = rs_q;
      out_wait_d  = (ctl.power_wait && idx_q == clni_pkg::INIT_FIRST)
                    ? clni_pkg::POWER_WAIT : clni_pkg::NO_WAIT;
      unique case (ctl.settle_sel)
        clni_pkg::STL_REQ:
          out_settle_d = long_q ? clni_pkg::SETTLE_LONG : clni_pkg::SETTLE_LOW;
        clni_pkg::STL_INIT:
          out_settle_d = (idx_q == clni_pkg::INIT_FIRST || idx_q == clni_pkg::INIT_CLEAR)
                         ? clni_pkg::SETTLE_LONG : clni_pkg::SETTLE_LOW;
        default:
          out_settle_d = clni_pkg::SETTLE_NONE;
      endcase
      out_last_d = 1'b0;
      unique case (ctl.seq)
        clni_pkg::SEQ_NEXT: begin
          pc_d = clni_pkg::pc_e'(pc_q + 1'b1);
        end
        clni_pkg::SEQ_LOOP_CNT: begin
          if (cnt_q == CntW'(1)) begin
            out_last_d = 1'b1;
            busy_d     = 1'b0;
          end else begin
            cnt_d = cnt_q - 1'b1;
            pc_d  = ctl.target;
          end
        end
        clni_pkg::SEQ_LOOP_INIT: begin
          if (idx_q == clni_pkg::INIT_LAST) begin
            out_last_d = 1'b1;
            busy_d     = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
            pc_d  = ctl.target;
          end
        end
        default: begin
          out_last_d = 1'b1;
          busy_d     = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= clni_pkg::PC_SINGLE_HI;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    rs_q         <= rs_d;
    long_q       <= long_d;
    cnt_q        <= cnt_d;
    idx_q        <= idx_d;
    out_nib_q    <= out_nib_d;
    out_rs_q     <= out_rs_d;
    out_wait_q   <= out_wait_d;
    out_settle_q <= out_settle_d;
    out_last_q   <= out_last_d;
  end

  // power-up wait only ahead of the first init nibble, a high command nibble of zero
  `CLNI_ASSERT_IMP(a_power_wait_first, clk_i, rst_ni, out_valid_q && out_wait_q != clni_pkg::NO_WAIT, out_nib_q == '0 && !out_rs_q, "power wait on wrong nibble")
  // long settle follows command nibbles only
  `CLNI_ASSERT_IMP(a_long_settle_cmd, clk_i, rst_ni, out_valid_q && out_settle_q == clni_pkg::SETTLE_LONG, !out_rs_q, "long settle after data nibble")
  // step counter stays inside the microprogram
  `CLNI_ASSERT_IMP(a_pc_range, clk_i, rst_ni, busy_q, pc_q <= clni_pkg::PC_INIT_LO, "step counter out of program")
  // a zero shift count produces no run
  `CLNI_ASSERT_NXT(a_zero_shift_idle, clk_i, rst_ni, accept && (op == clni_pkg::OP_SHIFT_L || op == clni_pkg::OP_SHIFT_R) && req_i.shift_count == '0, !busy_q, "zero shift started a run")

endmodule
